>>> rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared helpers for concurrent checks in the RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define ASSERT_IMPLIES(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("implication check failed");

// Next-cycle implication, disabled while reset is high.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("next-cycle check failed");

`endif

>>> rtl/owbm_pkg.sv
// ----------------------------------------------------------------------------
// owbm_pkg
// Types and constants for the 1-Wire bus master.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package owbm_pkg;

   // Tick timer width and its saturation value.
   localparam int TIMER_WIDTH = 10;
   localparam logic [TIMER_WIDTH-1:0] TIMER_MAX = {TIMER_WIDTH{1'b1}};

   // Width of the time registers and of the comparison against the timer.
   localparam int TIME_WIDTH = 10;
   localparam int CMP_WIDTH  = (TIMER_WIDTH > TIME_WIDTH) ? TIMER_WIDTH : TIME_WIDTH;

   // Configuration port.
   localparam int CSR_INDEX_WIDTH = 3;
   localparam int CSR_DATA_WIDTH  = 10;

   localparam logic [CSR_INDEX_WIDTH-1:0] REG_RESET_LOW    = 3'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_PRESENCE     = 3'd1;
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_RESET_TAIL   = 3'd2;
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_SLOT_LOW     = 3'd3;
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_SAMPLE_DELAY = 3'd4;
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_SLOT_TAIL    = 3'd5;
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_IDLE_LIMIT   = 3'd6;

   // Register defaults after reset.
   localparam logic [TIME_WIDTH-1:0] RESET_LOW_DEFAULT    = 10'd480;
   localparam logic [TIME_WIDTH-1:0] PRESENCE_DEFAULT     = 10'd66;
   localparam logic [TIME_WIDTH-1:0] RESET_TAIL_DEFAULT   = 10'd414;
   localparam logic [TIME_WIDTH-1:0] SLOT_LOW_DEFAULT     = 10'd1;
   localparam logic [TIME_WIDTH-1:0] SAMPLE_DELAY_DEFAULT = 10'd14;
   localparam logic [TIME_WIDTH-1:0] SLOT_TAIL_DEFAULT    = 10'd45;
   localparam logic [7:0]            IDLE_LIMIT_DEFAULT   = 8'd128;

   // Command codes.
   localparam logic [1:0] OP_TICK  = 2'd0;
   localparam logic [1:0] OP_RESET = 2'd1;
   localparam logic [1:0] OP_BYTE  = 2'd2;

   // Reset status codes.
   localparam logic [1:0] STATUS_PRESENCE = 2'd0;
   localparam logic [1:0] STATUS_NONE     = 2'd1;
   localparam logic [1:0] STATUS_STUCK    = 2'd2;

   // Last slot of a byte.
   localparam logic [2:0] LAST_SLOT = 3'd7;

   // Bus sequencer phases.
   typedef enum logic [7:0] {
      PH_IDLE      = 8'b0000_0001,
      PH_WAIT_HIGH = 8'b0000_0010,
      PH_RST_LOW   = 8'b0000_0100,
      PH_RST_REL   = 8'b0000_1000,
      PH_RST_TAIL  = 8'b0001_0000,
      PH_SLOT_LOW  = 8'b0010_0000,
      PH_SLOT_WAIT = 8'b0100_0000,
      PH_SLOT_TAIL = 8'b1000_0000
   } phase_type;

   // Input word: one bus tick.
   typedef struct packed {
      logic [1:0] op;
      logic [7:0] tx_byte;
      logic       line_level;
   } req_word_type;

   // Result word: bus drive and status for the tick.
   typedef struct packed {
      logic       drive_low;
      logic       busy_res;
      logic       done_res;
      logic [1:0] reset_status;
      logic [7:0] rx_byte;
   } rsp_word_type;

endpackage

>>> rtl/one_wire_bus_master.sv
// The result word for a tick is registered and presented in the cycle after its acceptance.
// Throughput: one tick word per cycle unless stalled; a single sequencer pass per word.
// A full result register lets a new word in whenever the result is taken that cycle.
// Reset (synchronous, active high) returns the sequencer to idle, clears the timers,
// the shift register and the status, and restores the timing registers to defaults.
// ----------------------------------------------------------------------------
// one_wire_bus_master
// Tick-driven 1-Wire master: reset/presence sequence and LSB-first byte slots.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module one_wire_bus_master
   import owbm_pkg::*;
(
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_stall,
   input  req_word_type               req_word,
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output rsp_word_type               rsp_word,
   input  logic                       csr_we,
   input  logic [CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [CSR_DATA_WIDTH-1:0]  csr_wdata
);

   // Timing registers.
   logic [TIME_WIDTH-1:0] reset_low_ff, presence_ff, reset_tail_ff;
   logic [TIME_WIDTH-1:0] slot_low_ff, sample_delay_ff, slot_tail_ff;
   logic [7:0]            idle_limit_ff;

   // Sequencer state.
   phase_type              phase_ff, phase_in;
   logic [TIMER_WIDTH-1:0] tick_timer_ff, tick_timer_in;
   logic [7:0]             idle_wait_ff, idle_wait_in;
   logic [2:0]             slot_index_ff, slot_index_in;
   logic [7:0]             shift_byte_ff, shift_byte_in;
   logic [1:0]             last_status_ff, last_status_in;

   // Result register.
   logic         rsp_valid_ff, rsp_valid_in;
   rsp_word_type rsp_word_ff, rsp_word_in;

   // Working values inside the single pass.
   phase_type              start_phase;
   logic [TIMER_WIDTH-1:0] start_timer, timer_inc;
   logic [7:0]             start_wait;
   logic [2:0]             start_slot;
   logic [7:0]             start_shift;
   logic [TIME_WIDTH-1:0]  phase_limit;
   logic                   timer_end;
   logic [7:0]             wait_inc;
   logic                   req_accept;
   logic                   drive, busy, done;

   // A new word enters when the result register is empty or is taken now.
   assign req_stall  = rsp_valid_ff & rsp_stall;
   assign req_accept = req_valid & ~req_stall;
   assign rsp_valid  = rsp_valid_ff;
   assign rsp_word   = rsp_word_ff;

   // Configuration writes; an index past the last register is ignored.
   always_ff @(posedge clock) begin
      if (reset) begin
         reset_low_ff    <= RESET_LOW_DEFAULT;
         presence_ff     <= PRESENCE_DEFAULT;
         reset_tail_ff   <= RESET_TAIL_DEFAULT;
         slot_low_ff     <= SLOT_LOW_DEFAULT;
         sample_delay_ff <= SAMPLE_DELAY_DEFAULT;
         slot_tail_ff    <= SLOT_TAIL_DEFAULT;
         idle_limit_ff   <= IDLE_LIMIT_DEFAULT;
      end else if (csr_we) begin
         unique case (csr_index)
            REG_RESET_LOW:    reset_low_ff    <= csr_wdata;
            REG_PRESENCE:     presence_ff     <= csr_wdata;
            REG_RESET_TAIL:   reset_tail_ff   <= csr_wdata;
            REG_SLOT_LOW:     slot_low_ff     <= csr_wdata;
            REG_SAMPLE_DELAY: sample_delay_ff <= csr_wdata;
            REG_SLOT_TAIL:    slot_tail_ff    <= csr_wdata;
            REG_IDLE_LIMIT:   idle_limit_ff   <= csr_wdata[7:0];
            default: ;
         endcase
      end
   end

   // Command start: an idle sequencer picks up a reset or a byte transfer.
   always_comb begin
      start_phase = phase_ff;
      start_timer = tick_timer_ff;
      start_wait  = idle_wait_ff;
      start_slot  = slot_index_ff;
      start_shift = shift_byte_ff;
      if (phase_ff == PH_IDLE) begin
         if (req_word.op == OP_RESET) begin
            start_phase = PH_WAIT_HIGH;
            start_wait  = '0;
         end else if (req_word.op == OP_BYTE) begin
            start_phase = PH_SLOT_LOW;
            start_timer = '0;
            start_slot  = '0;
            start_shift = req_word.tx_byte;
         end
      end
   end

   // Shared tick timer: saturating increment and end-of-phase compare.
   always_comb begin
      unique case (start_phase)
         PH_RST_LOW:   phase_limit = reset_low_ff;
         PH_RST_REL:   phase_limit = presence_ff;
         PH_RST_TAIL:  phase_limit = reset_tail_ff;
         PH_SLOT_LOW:  phase_limit = slot_low_ff;
         PH_SLOT_WAIT: phase_limit = sample_delay_ff;
         PH_SLOT_TAIL: phase_limit = slot_tail_ff;
         default:      phase_limit = '0;
      endcase
      timer_inc = (start_timer != TIMER_MAX) ? start_timer + 1'b1 : start_timer;
      timer_end = (CMP_WIDTH'(timer_inc) >= CMP_WIDTH'(phase_limit))
                  || (timer_inc == TIMER_MAX);
      wait_inc  = (start_wait != 8'hFF) ? start_wait + 8'd1 : start_wait;
   end

   // Phase sequencer: one step per tick.
   always_comb begin
      phase_in       = start_phase;
      tick_timer_in  = start_timer;
      idle_wait_in   = start_wait;
      slot_index_in  = start_slot;
      shift_byte_in  = start_shift;
      last_status_in = last_status_ff;
      drive          = 1'b0;
      done           = 1'b0;
      busy           = (start_phase != PH_IDLE);
      unique case (start_phase)
         PH_IDLE: begin
         end
         PH_WAIT_HIGH: begin
            if (req_word.line_level) begin
               phase_in      = PH_RST_LOW;
               tick_timer_in = '0;
            end else begin
               idle_wait_in = wait_inc;
               if (wait_inc >= idle_limit_ff) begin
                  last_status_in = STATUS_STUCK;
                  phase_in       = PH_IDLE;
                  done           = 1'b1;
               end
            end
         end
         PH_RST_LOW: begin
            drive         = 1'b1;
            tick_timer_in = timer_inc;
            if (timer_end) begin
               phase_in      = PH_RST_REL;
               tick_timer_in = '0;
            end
         end
         PH_RST_REL: begin
            tick_timer_in = timer_inc;
            if (timer_end) begin
               last_status_in = req_word.line_level ? STATUS_NONE : STATUS_PRESENCE;
               phase_in       = PH_RST_TAIL;
               tick_timer_in  = '0;
            end
         end
         PH_RST_TAIL: begin
            tick_timer_in = timer_inc;
            if (timer_end) begin
               phase_in = PH_IDLE;
               done     = 1'b1;
            end
         end
         PH_SLOT_LOW: begin
            drive         = 1'b1;
            tick_timer_in = timer_inc;
            if (timer_end) begin
               phase_in      = PH_SLOT_WAIT;
               tick_timer_in = '0;
            end
         end
         PH_SLOT_WAIT: begin
            // A one bit releases early; a zero bit keeps the line low.
            drive         = ~start_shift[0];
            tick_timer_in = timer_inc;
            if (timer_end) begin
               // Keep the outgoing bit for the tail, shift the sample in at the top.
               idle_wait_in  = {7'd0, start_shift[0]};
               shift_byte_in = {req_word.line_level, start_shift[7:1]};
               phase_in      = PH_SLOT_TAIL;
               tick_timer_in = '0;
            end
         end
         PH_SLOT_TAIL: begin
            drive         = ~start_wait[0];
            tick_timer_in = timer_inc;
            if (timer_end) begin
               if (start_slot >= LAST_SLOT) begin
                  slot_index_in = '0;
                  phase_in      = PH_IDLE;
                  done          = 1'b1;
               end else begin
                  slot_index_in = start_slot + 3'd1;
                  phase_in      = PH_SLOT_LOW;
                  tick_timer_in = '0;
               end
            end
         end
         default: begin
            phase_in = PH_IDLE;
         end
      endcase
   end

   // Result word for this tick.
   always_comb begin
      rsp_word_in.drive_low    = drive;
      rsp_word_in.busy_res     = busy;
      rsp_word_in.done_res     = done;
      rsp_word_in.reset_status = last_status_in;
      rsp_word_in.rx_byte      = shift_byte_in;
      if (req_accept) begin
         rsp_valid_in = 1'b1;
      end else if (~rsp_stall) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   // Sequencer state advances only on an accepted tick.
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff       <= PH_IDLE;
         tick_timer_ff  <= '0;
         idle_wait_ff   <= '0;
         slot_index_ff  <= '0;
         shift_byte_ff  <= '0;
         last_status_ff <= STATUS_PRESENCE;
         rsp_valid_ff   <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (req_accept) begin
            phase_ff       <= phase_in;
            tick_timer_ff  <= tick_timer_in;
            idle_wait_ff   <= idle_wait_in;
            slot_index_ff  <= slot_index_in;
            shift_byte_ff  <= shift_byte_in;
            last_status_ff <= last_status_in;
         end
      end
   end

   // Result payload register; loaded with the word for each accepted tick.
   always_ff @(posedge clock) begin
      if (req_accept) begin
         rsp_word_ff <= rsp_word_in;
      end
   end

   // A finished command leaves the sequencer idle.
   `ASSERT_IMPLIES(a_done_idle, clock, reset,
      rsp_valid_ff && rsp_word_ff.done_res, phase_ff == PH_IDLE)
   // A word that is not busy means nothing was started and the sequencer stays idle.
   `ASSERT_IMPLIES(a_not_busy_idle, clock, reset,
      rsp_valid_ff && !rsp_word_ff.busy_res, phase_ff == PH_IDLE)
   // The slot counter is only away from zero inside a byte transfer.
   `ASSERT_IMPLIES(a_slot_in_transfer, clock, reset, slot_index_ff != 3'd0,
      phase_ff == PH_SLOT_LOW || phase_ff == PH_SLOT_WAIT || phase_ff == PH_SLOT_TAIL)
   // A byte command taken while idle reports busy on its own tick.
   `ASSERT_NEXT(a_byte_start_busy, clock, reset,
      req_accept && phase_ff == PH_IDLE && req_word.op == OP_BYTE,
      rsp_valid_ff && rsp_word_ff.busy_res)

endmodule

>>> tb/sv/one_wire_bus_master_checker.sv
// ----------------------------------------------------------------------------
// one_wire_bus_master_checker
// Watches the tick and result channels of the 1-Wire master, predicts each
// result word from its own copy of the sequencer and the timing registers,
// and compares every accepted result word with the oldest prediction.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module one_wire_bus_master_checker
   import owbm_pkg::*;
(
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   input  logic                       req_stall,
   input  req_word_type               req_word,
   input  logic                       rsp_valid,
   input  logic                       rsp_stall,
   input  rsp_word_type               rsp_word,
   input  logic                       csr_we,
   input  logic [CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [CSR_DATA_WIDTH-1:0]  csr_wdata,
   input  logic                       run_done,
   output int                         fail_count
);

   // Predicted sequencer state.
   phase_type              bus_phase;
   logic [TIMER_WIDTH-1:0] tick_cnt;
   logic [7:0]             low_count;
   logic [2:0]             slot_cnt;
   logic [7:0]             shift_reg;
   logic [1:0]             bus_status;

   // Shadow copy of the timing registers.
   logic [TIME_WIDTH-1:0]  cfg_reset_low;
   logic [TIME_WIDTH-1:0]  cfg_presence;
   logic [TIME_WIDTH-1:0]  cfg_reset_tail;
   logic [TIME_WIDTH-1:0]  cfg_slot_low;
   logic [TIME_WIDTH-1:0]  cfg_sample_delay;
   logic [TIME_WIDTH-1:0]  cfg_slot_tail;
   logic [7:0]             cfg_idle_limit;

   rsp_word_type           pending_words[$];
   rsp_word_type           predicted;
   rsp_word_type           want;
   int                     errors = 0;
   int                     words_seen = 0;
   bit                     flushed = 1'b0;

   assign fail_count = errors;

   // Print one line per mismatch and count it.
   task automatic report(input string msg);
      $display("%t ns checker: %s", $realtime, msg);
      errors++;
   endtask

   // Count one tick of a timed phase; true on the last tick of the phase.
   // A limit of zero ends the phase after one tick, like a limit of one.
   function automatic logic timer_done(input logic [TIME_WIDTH-1:0] limit);
      if (tick_cnt != TIMER_MAX)
         tick_cnt = tick_cnt + 1'b1;
      return (CMP_WIDTH'(tick_cnt) >= CMP_WIDTH'(limit)) || (tick_cnt == TIMER_MAX);
   endfunction

   // Advance the predicted sequencer by one tick word.
   task automatic step_bus(input req_word_type w, output rsp_word_type r);
      logic drive;
      logic busy;
      logic done;
      drive = 1'b0;
      done  = 1'b0;

      // A command is only taken while idle; anything else is a plain tick.
      if (bus_phase == PH_IDLE) begin
         if (w.op == OP_RESET) begin
            bus_phase = PH_WAIT_HIGH;
            low_count = '0;
         end else if (w.op == OP_BYTE) begin
            bus_phase = PH_SLOT_LOW;
            tick_cnt  = '0;
            slot_cnt  = '0;
            shift_reg = w.tx_byte;
         end
      end
      busy = (bus_phase != PH_IDLE);

      case (bus_phase)
         PH_WAIT_HIGH: begin
            // The released line must read high before the reset pulse.
            if (w.line_level) begin
               bus_phase = PH_RST_LOW;
               tick_cnt  = '0;
            end else begin
               if (low_count != 8'hFF)
                  low_count = low_count + 1'b1;
               if (low_count >= cfg_idle_limit) begin
                  bus_status = STATUS_STUCK;
                  bus_phase  = PH_IDLE;
                  done       = 1'b1;
               end
            end
         end
         PH_RST_LOW: begin
            drive = 1'b1;
            if (timer_done(cfg_reset_low)) begin
               bus_phase = PH_RST_REL;
               tick_cnt  = '0;
            end
         end
         PH_RST_REL: begin
            // The presence answer is sampled on the last tick.
            if (timer_done(cfg_presence)) begin
               bus_status = w.line_level ? STATUS_NONE : STATUS_PRESENCE;
               bus_phase  = PH_RST_TAIL;
               tick_cnt   = '0;
            end
         end
         PH_RST_TAIL: begin
            if (timer_done(cfg_reset_tail)) begin
               bus_phase = PH_IDLE;
               done      = 1'b1;
            end
         end
         PH_SLOT_LOW: begin
            drive = 1'b1;
            if (timer_done(cfg_slot_low)) begin
               bus_phase = PH_SLOT_WAIT;
               tick_cnt  = '0;
            end
         end
         PH_SLOT_WAIT: begin
            // Release early for a one, keep driving for a zero.
            drive = ~shift_reg[0];
            if (timer_done(cfg_sample_delay)) begin
               low_count = {7'd0, shift_reg[0]};
               shift_reg = {w.line_level, shift_reg[7:1]};
               bus_phase = PH_SLOT_TAIL;
               tick_cnt  = '0;
            end
         end
         PH_SLOT_TAIL: begin
            // The outgoing bit of the slot is kept in the low counter.
            drive = ~low_count[0];
            if (timer_done(cfg_slot_tail)) begin
               if (slot_cnt == LAST_SLOT) begin
                  slot_cnt  = '0;
                  bus_phase = PH_IDLE;
                  done      = 1'b1;
               end else begin
                  slot_cnt  = slot_cnt + 1'b1;
                  bus_phase = PH_SLOT_LOW;
                  tick_cnt  = '0;
               end
            end
         end
         default: ;
      endcase

      r.drive_low    = drive;
      r.busy_res     = busy;
      r.done_res     = done;
      r.reset_status = bus_status;
      r.rx_byte      = shift_reg;
   endtask

   // Compare results first, then predict the word accepted on this edge, then
   // apply a register write, which takes effect from the next tick.
   always @(posedge clock) begin
      if (reset) begin
         bus_phase        = PH_IDLE;
         tick_cnt         = '0;
         low_count        = '0;
         slot_cnt         = '0;
         shift_reg        = '0;
         bus_status       = STATUS_PRESENCE;
         cfg_reset_low    = RESET_LOW_DEFAULT;
         cfg_presence     = PRESENCE_DEFAULT;
         cfg_reset_tail   = RESET_TAIL_DEFAULT;
         cfg_slot_low     = SLOT_LOW_DEFAULT;
         cfg_sample_delay = SAMPLE_DELAY_DEFAULT;
         cfg_slot_tail    = SLOT_TAIL_DEFAULT;
         cfg_idle_limit   = IDLE_LIMIT_DEFAULT;
         pending_words.delete();
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (pending_words.size() == 0) begin
               report("result word arrived with no tick outstanding");
            end else begin
               want = pending_words.pop_front();
               if (rsp_word.drive_low !== want.drive_low)
                  report($sformatf("word %0d drive_low expected %0d got %0d",
                                   words_seen, want.drive_low, rsp_word.drive_low));
               if (rsp_word.busy_res !== want.busy_res)
                  report($sformatf("word %0d busy_res expected %0d got %0d",
                                   words_seen, want.busy_res, rsp_word.busy_res));
               if (rsp_word.done_res !== want.done_res)
                  report($sformatf("word %0d done_res expected %0d got %0d",
                                   words_seen, want.done_res, rsp_word.done_res));
               if (rsp_word.reset_status !== want.reset_status)
                  report($sformatf("word %0d reset_status expected %0d got %0d",
                                   words_seen, want.reset_status, rsp_word.reset_status));
               if (rsp_word.rx_byte !== want.rx_byte)
                  report($sformatf("word %0d rx_byte expected %02h got %02h",
                                   words_seen, want.rx_byte, rsp_word.rx_byte));
            end
            words_seen++;
         end

         if (req_valid && !req_stall) begin
            step_bus(req_word, predicted);
            pending_words.push_back(predicted);
         end

         if (csr_we) begin
            case (csr_index)
               REG_RESET_LOW:    cfg_reset_low    = csr_wdata[TIME_WIDTH-1:0];
               REG_PRESENCE:     cfg_presence     = csr_wdata[TIME_WIDTH-1:0];
               REG_RESET_TAIL:   cfg_reset_tail   = csr_wdata[TIME_WIDTH-1:0];
               REG_SLOT_LOW:     cfg_slot_low     = csr_wdata[TIME_WIDTH-1:0];
               REG_SAMPLE_DELAY: cfg_sample_delay = csr_wdata[TIME_WIDTH-1:0];
               REG_SLOT_TAIL:    cfg_slot_tail    = csr_wdata[TIME_WIDTH-1:0];
               REG_IDLE_LIMIT:   cfg_idle_limit   = csr_wdata[7:0];
               default: ;
            endcase
         end

         // At the end of the run nothing may still be outstanding.
         if (run_done && !flushed) begin
            flushed = 1'b1;
            if (pending_words.size() != 0)
               report($sformatf("%0d expected result words never arrived",
                                pending_words.size()));
         end
      end
   end

endmodule

>>> tb/sv/tb_one_wire_bus_master.sv
// ----------------------------------------------------------------------------
// tb_one_wire_bus_master
// Drives tick words into the 1-Wire master: reset and byte commands with
// random line levels under default, zero, random and full-scale timing, with
// random gaps and result stalls. A checker beside the block predicts and
// compares every result word; this module gives the verdict.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_one_wire_bus_master;
   import owbm_pkg::*;

   // Codes outside the block's own set.
   localparam logic [1:0]                 OP_SPARE   = 2'd3;
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_UNUSED = 3'd7;
   localparam logic [TIME_WIDTH-1:0]      TIME_FULL  = {TIME_WIDTH{1'b1}};
   localparam logic [7:0]                 LIMIT_FULL = 8'hFF;
   localparam int SETTING_COUNT     = 4;
   localparam int WORDS_PER_SETTING = 50;

   logic                       clock     = 1'b0;
   logic                       reset     = 1'b1;
   logic                       req_valid = 1'b0;
   logic                       req_stall;
   req_word_type               req_word  = '0;
   logic                       rsp_valid;
   logic                       rsp_stall = 1'b0;
   rsp_word_type               rsp_word;
   logic                       csr_we    = 1'b0;
   logic [CSR_INDEX_WIDTH-1:0] csr_index = '0;
   logic [CSR_DATA_WIDTH-1:0]  csr_wdata = '0;
   logic                       run_done  = 1'b0;
   int                         fail_count;

   // Traffic bookkeeping.
   int req_count     = 0;
   int rsp_count     = 0;
   int done_count    = 0;
   int n_resets      = 0;
   int n_bytes       = 0;
   int settings_seen = 0;
   bit calm_tx       = 1'b0;
   bit calm_rx       = 1'b0;

   // Stimulus loop variables.
   int         s;
   int         phase_start;
   int         pause_at;
   int         p_high;
   int         guard;
   bit         paused;
   logic [1:0] cmd_op;
   logic [7:0] cmd_tx;
   logic [7:0] cmd_limit;

   one_wire_bus_master dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_word  (req_word),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_word  (rsp_word),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   one_wire_bus_master_checker checker_i (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_word   (req_word),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp_word   (rsp_word),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .run_done   (run_done),
      .fail_count (fail_count)
   );

   always #4 clock = ~clock;

   // Count accepted words on both channels and finished commands.
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && !req_stall)
            req_count <= req_count + 1;
         if (rsp_valid && !rsp_stall) begin
            rsp_count <= rsp_count + 1;
            if (rsp_word.done_res)
               done_count <= done_count + 1;
         end
      end
   end

   // Result side: after each taken word, stall the next one for a random time.
   int rsp_hold = 0;
   int rsp_seen = 0;
   always @(negedge clock) begin
      if (rsp_count != rsp_seen) begin
         rsp_seen = rsp_count;
         rsp_hold = calm_rx ? 0 : $urandom_range(0, 15);
      end
      if (rsp_hold > 0) begin
         rsp_stall <= 1'b1;
         if (rsp_valid)
            rsp_hold--;
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   // Line level that reads high with the given odds in percent.
   function automatic logic bus_level(input int odds);
      return ($urandom_range(0, 99) < odds);
   endfunction

   // Mostly short timing, sometimes zero, now and then longer.
   function automatic logic [TIME_WIDTH-1:0] pick_time();
      int sel;
      sel = $urandom_range(0, 7);
      if (sel == 0)
         return '0;
      if (sel == 7)
         return TIME_WIDTH'($urandom_range(4, 24));
      return TIME_WIDTH'($urandom_range(1, 3));
   endfunction

   // Present one tick word after a random gap and wait until it is taken.
   task automatic send_tick(input logic [1:0] op, input logic [7:0] tx, input logic line);
      req_word_type w;
      int           gap;
      w.op         = op;
      w.tx_byte    = tx;
      w.line_level = line;
      gap = calm_tx ? 0 : $urandom_range(0, 15);
      @(negedge clock);
      repeat (gap) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_word  <= w;
      do @(posedge clock); while (req_stall);
   endtask

   // Stop sending until every result word has come back.
   task automatic drain();
      @(negedge clock);
      req_valid <= 1'b0;
      while (rsp_count != req_count)
         @(negedge clock);
      repeat (2) @(negedge clock);
   endtask

   task automatic write_reg(input logic [CSR_INDEX_WIDTH-1:0] idx,
                            input logic [CSR_DATA_WIDTH-1:0] data);
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(negedge clock);
      csr_we    <= 1'b0;
   endtask

   // Write the whole timing set; only called while the block is idle.
   task automatic load_timing(input logic [TIME_WIDTH-1:0] rst_low,
                              input logic [TIME_WIDTH-1:0] presence,
                              input logic [TIME_WIDTH-1:0] rst_tail,
                              input logic [TIME_WIDTH-1:0] slot_low,
                              input logic [TIME_WIDTH-1:0] sample_dly,
                              input logic [TIME_WIDTH-1:0] slot_tail,
                              input logic [7:0]            limit);
      write_reg(REG_RESET_LOW, rst_low);
      write_reg(REG_PRESENCE, presence);
      write_reg(REG_RESET_TAIL, rst_tail);
      write_reg(REG_SLOT_LOW, slot_low);
      write_reg(REG_SAMPLE_DELAY, sample_dly);
      write_reg(REG_SLOT_TAIL, slot_tail);
      write_reg(REG_IDLE_LIMIT, {{(CSR_DATA_WIDTH-8){1'b0}}, limit});
      settings_seen++;
   endtask

   // Issue a command, then keep ticking until a finished command is seen.
   // With noise, some ticks carry commands that a busy block must ignore.
   task automatic run_command(input logic [1:0] op, input logic [7:0] tx,
                              input int odds, input int noise);
      int         start_done;
      logic [1:0] extra_op;
      start_done = done_count;
      calm_tx = ($urandom_range(0, 3) == 0);
      calm_rx = ($urandom_range(0, 3) == 0);
      if (op == OP_RESET)
         n_resets++;
      else
         n_bytes++;
      send_tick(op, tx, bus_level(odds));
      while (done_count == start_done) begin
         extra_op = OP_TICK;
         if ($urandom_range(0, 99) < noise)
            extra_op = $urandom_range(0, 1) ? OP_RESET : OP_BYTE;
         send_tick(extra_op, 8'($urandom_range(0, 255)), bus_level(odds));
      end
   endtask

   initial begin
      repeat (7) @(negedge clock);
      reset <= 1'b0;

      // Register defaults straight out of reset: a bus held low hits the default limit.
      run_command(OP_RESET, 8'h00, 0, 0);
      drain();

      // Zero timing behaves as one tick; a zero stuck limit trips on one low.
      load_timing('0, '0, '0, '0, '0, '0, '0);
      write_reg(REG_UNUSED, {CSR_DATA_WIDTH{1'b1}});
      run_command(OP_RESET, 8'h00, 100, 0);
      run_command(OP_RESET, 8'h00, 0, 0);
      run_command(OP_BYTE, 8'h5A, 50, 0);
      drain();

      // Short timing: presence both ways, stuck bus, edge bytes, busy commands.
      load_timing(10'd1, 10'd2, 10'd1, 10'd1, 10'd1, 10'd1, 8'd2);
      run_command(OP_RESET, 8'h00, 50, 0);
      run_command(OP_RESET, 8'h00, 0, 0);
      run_command(OP_BYTE, 8'h00, 50, 0);
      run_command(OP_BYTE, 8'hFF, 100, 0);
      run_command(OP_BYTE, 8'h80, 0, 0);
      run_command(OP_BYTE, 8'h01, 50, 50);
      send_tick(OP_SPARE, 8'hFF, 1'b1);
      send_tick(OP_TICK, 8'h00, 1'b0);
      drain();

      // Random settings, each with a stream of mostly well-formed commands.
      paused = 1'b0;
      for (s = 0; s < SETTING_COUNT; s++) begin
         case ($urandom_range(0, 7))
            0:       cmd_limit = 8'd0;
            7:       cmd_limit = 8'd40;
            default: cmd_limit = 8'($urandom_range(1, 6));
         endcase
         load_timing(pick_time(), pick_time(), pick_time(), pick_time(),
                     pick_time(), pick_time(), cmd_limit);
         phase_start = req_count;
         pause_at    = phase_start + $urandom_range(10, 40);
         while (req_count - phase_start < WORDS_PER_SETTING) begin
            // A few plain ticks at idle, now and then with the spare code.
            repeat ($urandom_range(0, 2))
               send_tick(($urandom_range(0, 7) == 0) ? OP_SPARE : OP_TICK,
                         8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
            cmd_op = ($urandom_range(0, 4) < 2) ? OP_RESET : OP_BYTE;
            case ($urandom_range(0, 5))
               0:       cmd_tx = 8'h00;
               1:       cmd_tx = 8'hFF;
               default: cmd_tx = 8'($urandom_range(0, 255));
            endcase
            case ($urandom_range(0, 3))
               0:       p_high = 0;
               1:       p_high = 50;
               2:       p_high = 85;
               default: p_high = 100;
            endcase
            run_command(cmd_op, cmd_tx, p_high, ($urandom_range(0, 3) == 0) ? 10 : 0);
            // Once in the run, hold the sender until every result is back.
            if (!paused && req_count >= pause_at) begin
               drain();
               paused = 1'b1;
            end
         end
         drain();
      end

      // Full-scale settings: a bus stuck low up to the highest limit.
      load_timing(TIME_FULL, TIME_FULL, TIME_FULL, TIME_FULL, TIME_FULL, TIME_FULL,
                  LIMIT_FULL);
      run_command(OP_RESET, 8'h00, 0, 0);

      // Let the last result words come back, within a bound.
      @(negedge clock);
      req_valid <= 1'b0;
      guard = 0;
      while (rsp_count != req_count && guard < 20000) begin
         @(negedge clock);
         guard++;
      end
      repeat (4) @(negedge clock);
      run_done <= 1'b1;
      repeat (2) @(negedge clock);

      $display("Summary: %0d tick words over %0d timing settings, zero and full scale included.",
               req_count, settings_seen);
      $display("Summary: %0d resets and %0d byte transfers commanded, %0d result words taken.",
               n_resets, n_bytes, rsp_count);
      if (fail_count == 0)
         $display("[one_wire_bus_master] OK");
      else
         $display("[one_wire_bus_master] ERROR");
      $finish;
   end

   // Watchdog for a hung handshake.
   initial begin
      #(8_000_000);
      $display("[one_wire_bus_master] ERROR");
      $finish;
   end

endmodule

>>> files.f
+incdir+rtl
rtl/owbm_pkg.sv
rtl/one_wire_bus_master.sv
tb/sv/one_wire_bus_master_checker.sv
tb/sv/tb_one_wire_bus_master.sv
